FILE: hw/rtl/lbh_pkg.sv
// Package for the lane-base column histogram block.
// Holds register codes, reset values, payload structs and the raster event struct.
// No dependencies.
`default_nettype none

package lbh_pkg;

  localparam int REG_W       = 12;
  localparam int BIN_COUNT_W = 5;
  localparam int COUNT_W     = 23;
  localparam int CFG_IDX_W   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_HEIGHT = 3'd4;

  localparam logic [REG_W-1:0]       FRAME_WIDTH_RST  = 12'd800;
  localparam logic [REG_W-1:0]       FRAME_HEIGHT_RST = 12'd600;
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST    = 5'd4;
  localparam logic [REG_W-1:0]       BIN_WIDTH_RST    = 12'd200;
  localparam logic [REG_W-1:0]       STRIP_HEIGHT_RST = 12'd50;

  typedef struct packed {
    logic [7:0] pixel_value;
  } pix_t;

  typedef struct packed {
    logic [3:0]         first_bin;
    logic [3:0]         second_bin;
    logic [11:0]        first_left_x;
    logic [11:0]        first_right_x;
    logic [11:0]        second_left_x;
    logic [11:0]        second_right_x;
    logic [10:0]        strip_top_y;
    logic [11:0]        strip_bottom_y;
    logic [COUNT_W-1:0] first_peak_count;
    logic [COUNT_W-1:0] second_peak_count;
  } res_t;

  // what the raster tracker says about the pixel at its position
  typedef struct packed {
    logic inc_req;
    logic frame_start;
    logic frame_end;
  } raster_evt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lbh_stream_ifs.sv
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on lbh_pkg for the payload structs.
`default_nettype none

interface lbh_pix_if;
  logic          valid;
  logic          ready;
  lbh_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbh_res_if;
  logic          valid;
  logic          ready;
  lbh_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lane_base_histogram_two_peaks_unit.sv
// Lane-base column histogram with two-peak pick: top level.
// Depends on lbh_pkg, lbh_stream_ifs, lbh_raster, lbh_bin_store, lbh_peak_pick.
//
// Usage:
//   pix carries one binary edge pixel per transfer, raster order. Nonzero pixels
//   in the bottom strip are counted per column bin in a small count memory.
//   Within a frame one pixel is taken every cycle; the increment is a
//   read-modify-write on the count memory with write-back forwarding.
//   After the last pixel of a frame, pix.ready drops while the memory is
//   drained and scanned one bin per cycle, then the result is loaded, once
//   the receiver has room; pix.ready returns together with res.valid. No
//   input is taken from the last pixel transfer until then.
//   res is a registered output; pixels of the next frame are taken while a
//   result waits. A stalled receiver only holds the block when the next
//   frame's result is ready to load and the previous one has not left.
//   The user writes configuration (cfg_we, cfg_idx, cfg_data) only while idle; the block does not check.
//   Reset (rst, synchronous) restores default registers, clears the raster
//   position and marks every bin empty; no memory clearing pass is needed.
`default_nettype none

module lane_base_histogram_two_peaks_unit #(
  parameter int MAX_BINS    = 16,
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbh_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lbh_pkg::REG_W-1:0]       cfg_data,
  lbh_pix_if.sink                         pix,
  lbh_res_if.source                       res
);
  import lbh_pkg::*;

  localparam int XW  = $clog2(MAX_COLUMNS+1);
  localparam int YW  = $clog2(MAX_ROWS+1);
  localparam int BNW = $clog2(MAX_BINS+1);
  localparam int AW  = $clog2(MAX_BINS);

  typedef enum logic [3:0] {
    S_RUN   = 4'b0001,
    S_DRAIN = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [REG_W-1:0]       frame_width, frame_height, bin_width, strip_height;
  logic [BIN_COUNT_W-1:0] bin_count;

  logic [XW-1:0]      fw_eff;
  logic [YW-1:0]      fh_eff, esh, top_y;
  logic [BNW-1:0]     nb_eff;
  logic [10:0]        top_y_out;
  logic [11:0]        bottom_y_out;

  raster_evt_t        evt;
  logic [AW-1:0]      bin_idx;
  logic               step, emit, can_load, scan_mode;
  logic [BNW-1:0]     scan_idx;
  logic               pv;
  logic [AW-1:0]      pidx;
  logic [COUNT_W-1:0] scan_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      bin_count    <= BIN_COUNT_RST;
      bin_width    <= BIN_WIDTH_RST;
      strip_height <= STRIP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BIN_COUNT:    bin_count    <= cfg_data[BIN_COUNT_W-1:0];
        REG_BIN_WIDTH:    bin_width    <= cfg_data;
        REG_STRIP_HEIGHT: strip_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped working values
  always_comb begin
    if (frame_width == '0) fw_eff = XW'(1);
    else if (32'(frame_width) > MAX_COLUMNS) fw_eff = XW'(MAX_COLUMNS);
    else fw_eff = XW'(frame_width);

    if (frame_height == '0) fh_eff = YW'(1);
    else if (32'(frame_height) > MAX_ROWS) fh_eff = YW'(MAX_ROWS);
    else fh_eff = YW'(frame_height);

    if (bin_count < BIN_COUNT_W'(2)) nb_eff = BNW'(2);
    else if (32'(bin_count) > MAX_BINS) nb_eff = BNW'(MAX_BINS);
    else nb_eff = BNW'(bin_count);

    if (32'(strip_height) > 32'(fh_eff)) esh = fh_eff;
    else esh = YW'(strip_height);
  end

  assign top_y        = fh_eff - esh;
  assign top_y_out    = (32'(top_y) > 32'd2047) ? 11'h7FF : 11'(top_y);
  assign bottom_y_out = 12'(fh_eff);

  assign pix.ready = (state == S_RUN);
  assign step      = pix.valid && pix.ready;
  assign scan_mode = (state == S_SCAN);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (state)
      S_RUN: begin
        if (step && evt.frame_end) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (pv && (BNW'(pidx) == nb_eff - 1'b1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          emit       = 1'b1;
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      pv       <= 1'b0;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      pv    <= scan_mode && (scan_idx < nb_eff);
      if (state == S_DRAIN) begin
        scan_idx <= '0;
      end else if (scan_mode && (scan_idx < nb_eff)) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= scan_idx[AW-1:0];
  end

  lbh_raster #(
    .MAX_BINS    (MAX_BINS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .nonzero   (pix.data.pixel_value != '0),
    .fw_eff    (fw_eff),
    .fh_eff    (fh_eff),
    .top_y     (top_y),
    .nb_eff    (nb_eff),
    .bin_width (bin_width),
    .evt       (evt),
    .bin_idx   (bin_idx)
  );

  lbh_bin_store #(
    .MAX_BINS (MAX_BINS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (step),
    .evt        (evt),
    .op_bin     (bin_idx),
    .scan_mode  (scan_mode),
    .scan_addr  (scan_idx[AW-1:0]),
    .scan_value (scan_value)
  );

  lbh_peak_pick #(
    .MAX_BINS (MAX_BINS)
  ) u_pick (
    .clk          (clk),
    .rst          (rst),
    .pv           (pv),
    .pidx         (pidx),
    .value        (scan_value),
    .emit         (emit),
    .bin_width    (bin_width),
    .top_y_out    (top_y_out),
    .bottom_y_out (bottom_y_out),
    .can_load     (can_load),
    .res          (res)
  );

`ifndef SYNTHESIS
  a_frame_end_drains: assert property (@(posedge clk) disable iff (rst)
    (step && evt.frame_end) |=> (state == S_DRAIN))
    else $error("last pixel of frame did not start the drain");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_EMIT))
    else $error("result raised outside the load step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    pv |-> (BNW'(pidx) < nb_eff))
    else $error("peak scan past the last bin");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lbh_raster.sv
// Raster position tracker: column, row, bin and column-in-bin counters.
// Flags frame start/end and whether the current pixel bumps a bin. Uses lbh_pkg.
`default_nettype none

module lbh_raster #(
  parameter int MAX_BINS    = 16,
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic                               nonzero,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]   fw_eff,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      fh_eff,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      top_y,
  input  logic [$clog2(MAX_BINS+1)-1:0]      nb_eff,
  input  logic [lbh_pkg::REG_W-1:0]          bin_width,
  output lbh_pkg::raster_evt_t               evt,
  output logic [$clog2(MAX_BINS)-1:0]        bin_idx
);
  import lbh_pkg::*;

  localparam int XW   = $clog2(MAX_COLUMNS+1);
  localparam int YW   = $clog2(MAX_ROWS+1);
  localparam int BNW  = $clog2(MAX_BINS+1);
  localparam int AW   = $clog2(MAX_BINS);
  localparam int CMPW = (XW + 1 > REG_W) ? XW + 1 : REG_W;

  logic [XW-1:0]   col, col_next, cib, cib_next;
  logic [YW-1:0]   row, row_next;
  logic [BNW-1:0]  cur, cur_next;
  logic [CMPW-1:0] cib_inc;
  logic            bin_done, row_done, frame_done, in_strip;

  assign cib_inc    = CMPW'(cib) + CMPW'(1);
  assign bin_done   = (bin_width != '0) && (cib_inc >= CMPW'(bin_width));
  assign row_done   = ({1'b0, col} + {{XW{1'b0}}, 1'b1}) >= {1'b0, fw_eff};
  assign frame_done = ({1'b0, row} + {{YW{1'b0}}, 1'b1}) >= {1'b0, fh_eff};
  assign in_strip   = (row >= top_y) && (row < fh_eff);

  assign evt.inc_req     = nonzero && in_strip && (bin_width != '0) && (cur < nb_eff);
  assign evt.frame_start = (row == '0) && (col == '0);
  assign evt.frame_end   = row_done && frame_done;
  assign bin_idx         = cur[AW-1:0];

  always_comb begin
    col_next = col + 1'b1;
    row_next = row;
    cib_next = cib + 1'b1;
    cur_next = cur;
    if (bin_done) begin
      cib_next = '0;
      if (cur != BNW'(MAX_BINS)) cur_next = cur + 1'b1;
    end
    if (row_done) begin
      col_next = '0;
      cib_next = '0;
      cur_next = '0;
      row_next = frame_done ? '0 : row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cib <= '0;
      cur <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
      cib <= cib_next;
      cur <= cur_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lbh_bin_store.sv
// Bin count memory with registered read, read-modify-write increment,
// write-back forwarding and per-bin valid bits cleared at frame start. Uses lbh_pkg.
`default_nettype none

module lbh_bin_store #(
  parameter int MAX_BINS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            op_valid,
  input  lbh_pkg::raster_evt_t            evt,
  input  logic [$clog2(MAX_BINS)-1:0]     op_bin,
  input  logic                            scan_mode,
  input  logic [$clog2(MAX_BINS)-1:0]     scan_addr,
  output logic [lbh_pkg::COUNT_W-1:0]     scan_value
);
  import lbh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);

  logic [COUNT_W-1:0]  mem [MAX_BINS];
  logic [COUNT_W-1:0]  rd_data;
  logic [AW-1:0]       rd_addr, rd_addr_q;
  logic [MAX_BINS-1:0] bin_valid;

  logic                s1_valid;
  logic [AW-1:0]       s1_bin;
  logic                wb_valid;
  logic [AW-1:0]       wb_bin;
  logic [COUNT_W-1:0]  wb_data;
  logic [COUNT_W-1:0]  base;
  logic                wr_en;

  assign rd_addr = scan_mode ? scan_addr : op_bin;

  // last write lands on the same edge as the next read, so forward it
  always_comb begin
    if (!bin_valid[s1_bin]) begin
      base = '0;
    end else if (wb_valid && (wb_bin == s1_bin)) begin
      base = wb_data;
    end else begin
      base = rd_data;
    end
  end

  assign wr_en      = s1_valid && (base != COUNT_MAX);
  assign scan_value = bin_valid[rd_addr_q] ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[s1_bin] <= base + 1'b1;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    s1_bin    <= op_bin;
    wb_bin    <= s1_bin;
    wb_data   <= base + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      bin_valid <= '0;
    end else begin
      s1_valid <= op_valid && evt.inc_req;
      wb_valid <= wr_en;
      if (op_valid && evt.frame_start) begin
        bin_valid <= '0;
      end else if (wr_en) begin
        bin_valid[s1_bin] <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_when_drained: assert property (@(posedge clk) disable iff (rst)
    (op_valid && evt.frame_start) |-> (!s1_valid && !wb_valid))
    else $error("frame clear overlaps an increment in flight");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> bin_valid[$past(s1_bin)])
    else $error("written bin not marked valid");

  a_scan_no_pixels: assert property (@(posedge clk) disable iff (rst)
    scan_mode |-> !op_valid)
    else $error("pixel transfer during peak scan");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lbh_peak_pick.sv
// Two-peak scan over streamed bin counts, bound computation and result register.
// Depends on lbh_pkg and lbh_res_if.
`default_nettype none

module lbh_peak_pick #(
  parameter int MAX_BINS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pv,
  input  logic [$clog2(MAX_BINS)-1:0]     pidx,
  input  logic [lbh_pkg::COUNT_W-1:0]     value,
  input  logic                            emit,
  input  logic [lbh_pkg::REG_W-1:0]       bin_width,
  input  logic [10:0]                     top_y_out,
  input  logic [11:0]                     bottom_y_out,
  output logic                            can_load,
  lbh_res_if.source                       res
);
  import lbh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int PW = AW + REG_W + 1;

  logic [AW-1:0]      first, second;
  logic [COUNT_W-1:0] fc, sc;
  logic [PW-1:0]      f_left, f_right, s_left, s_right;

  always_ff @(posedge clk) begin
    if (pv) begin
      if (pidx == '0) begin
        first <= '0;
        fc    <= value;
      end else if (pidx == AW'(1)) begin
        // seed pair: bin 0 keeps first place on a tie
        if (fc >= value) begin
          second <= pidx;
          sc     <= value;
        end else begin
          first  <= pidx;
          fc     <= value;
          second <= first;
          sc     <= fc;
        end
      end else if (fc <= value) begin
        second <= first;
        sc     <= fc;
        first  <= pidx;
        fc     <= value;
      end else if (sc < value) begin
        second <= pidx;
        sc     <= value;
      end
    end
  end

  assign f_left  = PW'(first) * PW'(bin_width);
  assign f_right = f_left + PW'(bin_width);
  assign s_left  = PW'(second) * PW'(bin_width);
  assign s_right = s_left + PW'(bin_width);

  assign can_load = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.data.first_bin         <= 4'(first);
      res.data.second_bin        <= 4'(second);
      res.data.first_left_x      <= (f_left  > PW'(12'hFFF)) ? 12'hFFF : f_left[11:0];
      res.data.first_right_x     <= (f_right > PW'(12'hFFF)) ? 12'hFFF : f_right[11:0];
      res.data.second_left_x     <= (s_left  > PW'(12'hFFF)) ? 12'hFFF : s_left[11:0];
      res.data.second_right_x    <= (s_right > PW'(12'hFFF)) ? 12'hFFF : s_right[11:0];
      res.data.strip_top_y       <= top_y_out;
      res.data.strip_bottom_y    <= bottom_y_out;
      res.data.first_peak_count  <= fc;
      res.data.second_peak_count <= sc;
    end
  end

endmodule

`default_nettype wire

FILE: tb/lane_base_histogram_two_peaks_unit_tb.sv
// Testbench for lane_base_histogram_two_peaks_unit: edge frames under many register
// settings, each result checked against an in-bench model of the histogram and peak pick.
// Depends on lbh_pkg, lbh_stream_ifs and the unit RTL.
module lane_base_histogram_two_peaks_unit_tb;
  import lbh_pkg::*;

  localparam int unsigned NBINS = 16;
  localparam int unsigned NCOLS = 2048;
  localparam int unsigned NROWS = 2048;
  localparam int IDLE_WAIT = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_data;

  lbh_pix_if pix();
  lbh_res_if res();

  lane_base_histogram_two_peaks_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .pix(pix), .res(res)
  );

  // shadow registers and raster/histogram state
  logic [REG_W-1:0]       frame_w, frame_h, bin_w, strip_h;
  logic [BIN_COUNT_W-1:0] bins_reg;
  logic [COUNT_W-1:0]     bin_cnt [NBINS];
  logic [10:0]            col_pos, row_pos, col_in_bin;
  logic [4:0]             cur_bin;

  pix_t pixel_q[$];
  res_t peak_q[$];
  res_t new_peak, oldest_peak;
  int   queued = 0, accepted = 0, frames_done = 0, errors = 0;
  int   pix_gap = 0, res_stall = 0;
  bit   pix_quiet = 1'b0, res_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [11:0] sat12(input int unsigned v);
    return v > 4095 ? 12'hFFF : v[11:0];
  endfunction

  // One pixel through the histogram; returns 1 with the peak pair on the last pixel.
  function automatic bit count_pixel(input logic [7:0] px, output res_t pk);
    int unsigned fw, fh, nb, esh, first, second, fc, sc, top, i;
    fw  = frame_w == 0 ? 1 : (frame_w > NCOLS ? NCOLS : frame_w);
    fh  = frame_h == 0 ? 1 : (frame_h > NROWS ? NROWS : frame_h);
    nb  = bins_reg < 2 ? 2 : (bins_reg > NBINS ? NBINS : bins_reg);
    esh = strip_h > fh ? fh : strip_h;
    pk  = '0;
    if (row_pos == 0 && col_pos == 0)
      foreach (bin_cnt[b]) bin_cnt[b] = '0;
    if (px != 0 && row_pos >= fh - esh && row_pos < fh && bin_w != 0 && cur_bin < nb &&
        bin_cnt[cur_bin] != COUNT_MAX)
      bin_cnt[cur_bin]++;

    if (bin_w != 0 && col_in_bin + 32'd1 >= bin_w) begin
      col_in_bin = '0;
      if (cur_bin < NBINS) cur_bin++;
    end else begin
      col_in_bin++;
    end

    if (col_pos + 32'd1 >= fw) begin
      col_pos    = '0;
      cur_bin    = '0;
      col_in_bin = '0;
      if (row_pos + 32'd1 >= fh) begin
        row_pos = '0;
        // bins 0 and 1 seed the pair; a later bin takes first place on a tie
        if (bin_cnt[0] >= bin_cnt[1]) begin
          first = 0; second = 1;
        end else begin
          first = 1; second = 0;
        end
        fc = bin_cnt[first];
        sc = bin_cnt[second];
        for (i = 2; i < nb; i++) begin
          if (fc <= bin_cnt[i]) begin
            sc = fc; second = first;
            fc = bin_cnt[i]; first = i;
          end else if (sc < bin_cnt[i]) begin
            sc = bin_cnt[i]; second = i;
          end
        end
        top = fh - esh;
        pk.first_bin         = first[3:0];
        pk.second_bin        = second[3:0];
        pk.first_left_x      = sat12(first * bin_w);
        pk.first_right_x     = sat12((first + 1) * bin_w);
        pk.second_left_x     = sat12(second * bin_w);
        pk.second_right_x    = sat12((second + 1) * bin_w);
        pk.strip_top_y       = top > 2047 ? 11'h7FF : top[10:0];
        pk.strip_bottom_y    = sat12(fh);
        pk.first_peak_count  = fc[COUNT_W-1:0];
        pk.second_peak_count = sc[COUNT_W-1:0];
        return 1'b1;
      end
      row_pos++;
    end else begin
      col_pos++;
    end
    return 1'b0;
  endfunction

  function automatic int pick_wait(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // model update: register writes and accepted pixels
  always @(posedge clk) begin
    if (rst) begin
      frame_w    = FRAME_WIDTH_RST;
      frame_h    = FRAME_HEIGHT_RST;
      bins_reg   = BIN_COUNT_RST;
      bin_w      = BIN_WIDTH_RST;
      strip_h    = STRIP_HEIGHT_RST;
      foreach (bin_cnt[b]) bin_cnt[b] = '0;
      col_pos    = '0;
      row_pos    = '0;
      col_in_bin = '0;
      cur_bin    = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FRAME_WIDTH:  frame_w  = cfg_data;
          REG_FRAME_HEIGHT: frame_h  = cfg_data;
          REG_BIN_COUNT:    bins_reg = cfg_data[BIN_COUNT_W-1:0];
          REG_BIN_WIDTH:    bin_w    = cfg_data;
          REG_STRIP_HEIGHT: strip_h  = cfg_data;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        accepted++;
        if (count_pixel(pix.data.pixel_value, new_peak)) begin
          peak_q.insert(peak_q.size(), new_peak);
          frames_done++;
        end
      end
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pix.data  <= '0;
      pix_gap   <= 0;
    end else begin
      if ($urandom_range(199) == 0) pix_quiet <= !pix_quiet;
      if (!pix.valid || pix.ready) begin
        if (pix_gap == 0 && pixel_q.size() != 0) begin
          pix.valid <= 1'b1;
          pix.data  <= pixel_q.pop_front();
          pix_gap   <= pick_wait(pix_quiet);
        end else begin
          pix.valid <= 1'b0;
          if (pix_gap != 0) pix_gap <= pix_gap - 1;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      res_stall <= 0;
    end else begin
      if ($urandom_range(199) == 0) res_quiet <= !res_quiet;
      if (res.valid && res.ready) begin
        if (peak_q.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          oldest_peak = peak_q.pop_front();
          check_field("first_bin", oldest_peak.first_bin, res.data.first_bin);
          check_field("second_bin", oldest_peak.second_bin, res.data.second_bin);
          check_field("first_left_x", oldest_peak.first_left_x, res.data.first_left_x);
          check_field("first_right_x", oldest_peak.first_right_x, res.data.first_right_x);
          check_field("second_left_x", oldest_peak.second_left_x, res.data.second_left_x);
          check_field("second_right_x", oldest_peak.second_right_x,
                      res.data.second_right_x);
          check_field("strip_top_y", oldest_peak.strip_top_y, res.data.strip_top_y);
          check_field("strip_bottom_y", oldest_peak.strip_bottom_y,
                      res.data.strip_bottom_y);
          check_field("first_peak_count", oldest_peak.first_peak_count,
                      res.data.first_peak_count);
          check_field("second_peak_count", oldest_peak.second_peak_count,
                      res.data.second_peak_count);
        end
      end
      if (res_stall != 0) begin
        res.ready <= 1'b0;
        res_stall <= res_stall - 1;
      end else begin
        res.ready <= 1'b1;
        res_stall <= pick_wait(res_quiet);
      end
    end
  end

  // all queued pixels taken, all results out, then let the pipeline drain
  task automatic wait_idle();
    do @(posedge clk); while (accepted != queued || peak_q.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [11:0] fw, fh, bc, bw, sh);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= REG_FRAME_WIDTH;  cfg_data <= fw;
    @(posedge clk);
    cfg_idx <= REG_FRAME_HEIGHT; cfg_data <= fh;
    @(posedge clk);
    cfg_idx <= REG_BIN_COUNT;    cfg_data <= bc;
    @(posedge clk);
    cfg_idx <= REG_BIN_WIDTH;    cfg_data <= bw;
    @(posedge clk);
    cfg_idx <= REG_STRIP_HEIGHT; cfg_data <= sh;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(input bit hot);
    pix_t p;
    p.pixel_value = hot ? 8'($urandom_range(255, 1)) : 8'd0;
    pixel_q.insert(pixel_q.size(), p);
    queued++;
  endtask

  // Queue whole frames at the current setting. kind < 0 picks a fill per frame
  // (0 empty, 1 full, else a density per bin). cut > 0 adds a partial frame of
  // that many pixels, cut < 0 one of random length.
  task automatic queue_frames(input int frames, input int cut, input int kind);
    int fw, fh, bw, c, r, n, f, b, stop, fill;
    int dens [16];
    fw = frame_w == 0 ? 1 : (frame_w > NCOLS ? NCOLS : frame_w);
    fh = frame_h == 0 ? 1 : (frame_h > NROWS ? NROWS : frame_h);
    bw = bin_w == 0 ? 1 : bin_w;
    // close a frame left open by an earlier phase
    c = col_pos;
    r = row_pos;
    if (c != 0 || r != 0) begin
      while (1) begin
        queue_pixel($urandom_range(1));
        if (c + 1 >= fw) begin
          c = 0;
          if (r + 1 >= fh) break;
          r++;
        end else begin
          c++;
        end
      end
    end
    for (f = 0; f < frames + (cut != 0); f++) begin
      fill = kind < 0 ? $urandom_range(9) : kind;
      for (b = 0; b < 16; b++)
        dens[b] = fill == 0 ? 0 : fill == 1 ? 100 : fill < 5 ? 50 : $urandom_range(100);
      if (f < frames) stop = fw * fh;
      else stop = cut > 0 ? cut : $urandom_range(fw * fh - 1, 0);
      n = 0;
      for (r = 0; r < fh && n < stop; r++)
        for (c = 0; c < fw && n < stop; c++) begin
          b = c / bw;
          if (b > 15) b = 15;
          queue_pixel($urandom_range(99) < dens[b]);
          n++;
        end
    end
  endtask

  initial begin
    int fw, fh, bc, bce, bw, sh, r;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_idx   = REG_FRAME_WIDTH;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.data  = '0;
    res.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // two bins: empty frame (tie), full frame, uneven frame
    write_cfg(8, 4, 2, 4, 2);
    queue_frames(1, 0, 0);
    queue_frames(1, 0, 1);
    queue_frames(1, 0, 5);
    // sixteen one-column bins; an empty frame walks the tie to the last bins
    write_cfg(16, 3, 16, 1, 3);
    queue_frames(1, 0, 6);
    queue_frames(1, 0, 0);
    // single-pixel frames
    write_cfg(1, 1, 2, 1, 1);
    queue_frames(3, 0, -1);
    // bin count below range, zero bin width
    write_cfg(5, 2, 0, 0, 2);
    queue_frames(1, 0, 1);
    // bin count above range, huge bin width: x bounds saturate
    write_cfg(6, 2, 31, 4095, 1);
    queue_frames(1, 0, 0);
    queue_frames(1, 0, 1);
    // columns past the last bin
    write_cfg(12, 3, 2, 3, 1);
    queue_frames(1, 0, 1);
    // strip taller than the frame, then an empty strip
    write_cfg(7, 3, 3, 2, 4095);
    queue_frames(1, 0, -1);
    write_cfg(7, 3, 3, 2, 0);
    queue_frames(1, 0, 1);
    // registers changed inside a frame: width below the column, height below the row
    write_cfg(8, 4, 4, 2, 4);
    queue_frames(0, 13, 1);
    write_cfg(3, 4, 4, 2, 4);
    queue_frames(0, 7, -1);
    write_cfg(3, 1, 2, 1, 1);
    queue_frames(1, 0, -1);
    // zero frame sizes clamp to one
    write_cfg(0, 0, 16, 128, 1);
    queue_frames(2, 0, -1);
    write_cfg(0, 5, 2, 1, 0);
    queue_frames(1, 0, 1);
    write_cfg(9, 0, 5, 1, 4095);
    queue_frames(1, 0, -1);

    // random settings, mostly small frames
    while (queued < 1450) begin
      fw  = $urandom_range(24, 1);
      fh  = $urandom_range(8, 1);
      bc  = $urandom_range(9) == 0 ? $urandom_range(31, 0) : $urandom_range(16, 2);
      bce = bc < 2 ? 2 : (bc > 16 ? 16 : bc);
      r   = $urandom_range(9);
      if (r == 0) bw = 0;
      else if (r == 1) bw = $urandom_range(4095, 25);
      else if (r < 6) bw = fw / bce == 0 ? 1 : fw / bce;
      else bw = $urandom_range(fw, 1);
      r = $urandom_range(9);
      if (r == 0) sh = 0;
      else if (r == 1) sh = $urandom_range(4095, fh);
      else sh = $urandom_range(fh, 1);
      // upper data bits on a bin count write are don't-care
      if ($urandom_range(3) == 0) bc = bc | ($urandom_range(127) << 5);
      write_cfg(fw, fh, bc, bw, sh);
      queue_frames($urandom_range(3, 1), $urandom_range(9) == 0 ? -1 : 0, -1);
    end

    wait_idle();
    if (errors == 0 && peak_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
